>>> rtl/cmdc_pkg.sv
`default_nettype none

package cmdc_pkg;

	// Field and register widths.
	localparam int REG_W     = 24;
	localparam int IDX_W     = 5;
	localparam int CFG_IDX_W = 1;
	localparam int COUNT_W   = 32;
	localparam int ROOT_W    = COUNT_W / 2;

	// Defaults of the top level parameters.
	localparam int TIME_BITS_DEF   = 48;
	localparam int BATCH_SLOTS_DEF = 32;

	// Register reset values; a write of zero also restores them.
	localparam logic [REG_W-1:0] TARGET_DEFAULT   = REG_W'(5000);
	localparam logic [REG_W-1:0] INTERVAL_DEFAULT = REG_W'(100000);

	// Quick re-entry window is eight intervals, a shift by three.
	localparam int REENTRY_SHIFT = 3;

	// Register indexes on the configuration port.
	localparam logic [CFG_IDX_W-1:0] REG_TARGET   = 1'b0;
	localparam logic [CFG_IDX_W-1:0] REG_INTERVAL = 1'b1;

	typedef enum logic [1:0] {
		ACT_NONE = 2'd0,
		ACT_MARK = 2'd1,
		ACT_DROP = 2'd2
	} action_t;

endpackage

`default_nettype wire

>>> rtl/codel_mark_drop_controller_core.sv
`default_nettype none

// Channel  | Handshake              | Payload
// ---------+------------------------+-----------------------------------------------
// input    | in_valid / in_ready    | now_time, batch_open_time, markable_found,
//          |                        | markable_index
// output   | out_valid / out_ready  | action, mark_position
// config   | cfg_wr_en (no wait)    | cfg_index, cfg_wdata
//
// A request passes S_DIFF, S_HEALTH and S_OUT back to idle when the batch is healthy
// or still in its grace interval, and also S_ARM when it starts the grace interval.
// Each run of the control law has a start state, the serial square root, a
// handoff, the serial divider, and then takes the step and adds it. A
// request that enters the dropping state and signals at once runs the law twice.
// Reset leaves both registers at their defaults and the controller idle with
// no grace deadline. A new request is accepted while a result still waits on
// the output register; a finished result waits in its final state while the
// output register is still full and out_ready is low.
module codel_mark_drop_controller_core #(
	parameter int BATCH_SLOTS = cmdc_pkg::BATCH_SLOTS_DEF,
	parameter int TIME_BITS   = cmdc_pkg::TIME_BITS_DEF
) (
	input  wire logic                           clk,
	input  wire logic                           arst_n,

	input  wire logic                           in_valid,
	output logic                                in_ready,
	input  wire logic [TIME_BITS-1:0]           now_time,
	input  wire logic [TIME_BITS-1:0]           batch_open_time,
	input  wire logic                           markable_found,
	input  wire logic [cmdc_pkg::IDX_W-1:0]     markable_index,

	output logic                                out_valid,
	input  wire logic                           out_ready,
	output logic      [1:0]                     action,
	output logic      [cmdc_pkg::IDX_W-1:0]     mark_position,

	input  wire logic                           cfg_wr_en,
	input  wire logic [cmdc_pkg::CFG_IDX_W-1:0] cfg_index,
	input  wire logic [cmdc_pkg::REG_W-1:0]     cfg_wdata
);
	import cmdc_pkg::*;

	localparam int TB = TIME_BITS;

	typedef enum logic [3:0] {
		S_IDLE,
		S_DIFF,
		S_HEALTH,
		S_ARM,
		S_ENTER,
		S_REC,
		S_LAW_GO,
		S_LAW,
		S_ADD,
		S_CMP,
		S_OUT
	} state_t;

	state_t state_q;

	// Configuration registers.
	logic [REG_W-1:0] target_q;
	logic [REG_W-1:0] interval_q;

	// Captured request.
	logic [TB-1:0]    now_q;
	logic [TB-1:0]    open_q;
	logic             found_q;
	logic [IDX_W-1:0] idx_q;

	// Controller state.
	logic [TB-1:0]      above_q;
	logic               drop_q;
	logic [COUNT_W-1:0] count_q;
	logic [COUNT_W-1:0] prev_q;
	logic [TB-1:0]      next_q;

	// Working registers.
	logic [TB-1:0]    diff_q;
	logic             neg_q;
	logic [TB-1:0]    base_q;
	logic             second_q;
	action_t          res_action_q;
	logic [IDX_W-1:0] res_pos_q;

	// Output register.
	logic             out_valid_q;
	action_t          action_q;
	logic [IDX_W-1:0] mark_q;

	// Control law units.
	logic [ROOT_W-1:0] root;
	logic              root_done;
	logic [ROOT_W-1:0] divisor;
	logic [REG_W-1:0]  step;
	logic              step_done;

	// Shared time arithmetic.
	logic [TB-1:0] sub_b;
	logic [TB:0]   diff_w;
	logic [TB-1:0] add_a;
	logic [REG_W-1:0] add_b;
	logic [TB:0]   sum_w;
	logic [TB-1:0] sat_w;
	logic          healthy;
	logic          recent;
	logic [COUNT_W-1:0] count_inc;

	cmdc_isqrt u_isqrt (
		.clk     (clk),
		.arst_n  (arst_n),
		.start   (state_q == S_LAW_GO),
		.operand (count_q),
		.root    (root),
		.done    (root_done)
	);

	// A count of zero has a root of zero; the step is then one whole interval.
	assign divisor = (root == '0) ? ROOT_W'(1) : root;

	cmdc_div u_div (
		.clk      (clk),
		.arst_n   (arst_n),
		.start    (root_done),
		.dividend (interval_q),
		.divisor  (divisor),
		.quotient (step),
		.done     (step_done)
	);

	// The subtractor gives the batch age, and when entering the dropping state
	// the distance from the last scheduled action; the top bit is the borrow.
	assign sub_b  = (state_q == S_ENTER) ? next_q : open_q;
	assign diff_w = {1'b0, now_q} - {1'b0, sub_b};

	// Saturating time add: the grace deadline, or a schedule advance.
	assign add_a = (state_q == S_ARM) ? now_q : base_q;
	assign add_b = (state_q == S_ARM) ? interval_q : step;
	assign sum_w = {1'b0, add_a} + {{(TB + 1 - REG_W){1'b0}}, add_b};
	assign sat_w = sum_w[TB] ? '1 : sum_w[TB-1:0];

	// An open time after now counts as healthy.
	assign healthy = neg_q || (diff_q <= {{(TB - REG_W){1'b0}}, target_q});

	// A schedule still ahead of now counts as a quick re-entry.
	assign recent = neg_q ||
		(diff_q < {{(TB - REG_W - REENTRY_SHIFT){1'b0}}, interval_q,
		{REENTRY_SHIFT{1'b0}}});

	assign count_inc = (count_q == '1) ? count_q : count_q + COUNT_W'(1);

	always_ff @(posedge clk or negedge arst_n) begin
		if (!arst_n) begin
			target_q   <= TARGET_DEFAULT;
			interval_q <= INTERVAL_DEFAULT;
		end else if (cfg_wr_en) begin
			case (cfg_index)
				REG_TARGET: begin
					target_q <= (cfg_wdata == '0) ? TARGET_DEFAULT : cfg_wdata;
				end
				REG_INTERVAL: begin
					interval_q <= (cfg_wdata == '0) ? INTERVAL_DEFAULT : cfg_wdata;
				end
				default: begin
				end
			endcase
		end
	end

	always_ff @(posedge clk or negedge arst_n) begin
		if (!arst_n) begin
			state_q      <= S_IDLE;
			now_q        <= '0;
			open_q       <= '0;
			found_q      <= 1'b0;
			idx_q        <= '0;
			above_q      <= '0;
			drop_q       <= 1'b0;
			count_q      <= '0;
			prev_q       <= '0;
			next_q       <= '0;
			diff_q       <= '0;
			neg_q        <= 1'b0;
			base_q       <= '0;
			second_q     <= 1'b0;
			res_action_q <= ACT_NONE;
			res_pos_q    <= '0;
			out_valid_q  <= 1'b0;
			action_q     <= ACT_NONE;
			mark_q       <= '0;
		end else begin
			// In S_OUT the output register is reloaded or held by the state below.
			if (out_valid_q && out_ready && (state_q != S_OUT)) begin
				out_valid_q <= 1'b0;
			end

			case (state_q)
				S_IDLE: begin
					if (in_valid) begin
						now_q        <= now_time;
						open_q       <= batch_open_time;
						found_q      <= markable_found;
						idx_q        <= markable_index;
						res_action_q <= ACT_NONE;
						res_pos_q    <= '0;
						state_q      <= S_DIFF;
					end
				end

				S_DIFF: begin
					diff_q  <= diff_w[TB-1:0];
					neg_q   <= diff_w[TB];
					state_q <= S_HEALTH;
				end

				S_HEALTH: begin
					if (healthy) begin
						above_q <= '0;
						drop_q  <= 1'b0;
						state_q <= S_OUT;
					end else if (above_q == '0) begin
						state_q <= S_ARM;
					end else if (now_q < above_q) begin
						state_q <= S_OUT;
					end else if (!drop_q) begin
						state_q <= S_ENTER;
					end else begin
						state_q <= S_CMP;
					end
				end

				S_ARM: begin
					above_q <= sat_w;
					state_q <= S_OUT;
				end

				S_ENTER: begin
					drop_q  <= 1'b1;
					diff_q  <= diff_w[TB-1:0];
					neg_q   <= diff_w[TB];
					state_q <= S_REC;
				end

				S_REC: begin
					// Quick re-entry resumes from the count of the last entry.
					if ((count_q > COUNT_W'(2)) && recent) begin
						count_q <= prev_q;
					end else begin
						count_q <= COUNT_W'(1);
						prev_q  <= COUNT_W'(1);
					end
					base_q   <= now_q;
					second_q <= 1'b0;
					state_q  <= S_LAW_GO;
				end

				S_LAW_GO: begin
					state_q <= S_LAW;
				end

				S_LAW: begin
					if (step_done) begin
						state_q <= S_ADD;
					end
				end

				S_ADD: begin
					next_q  <= sat_w;
					state_q <= second_q ? S_OUT : S_CMP;
				end

				S_CMP: begin
					if (now_q < next_q) begin
						state_q <= S_OUT;
					end else begin
						if (found_q && (int'(idx_q) < BATCH_SLOTS)) begin
							res_action_q <= ACT_MARK;
							res_pos_q    <= idx_q;
						end else begin
							res_action_q <= ACT_DROP;
							res_pos_q    <= '0;
						end
						count_q  <= count_inc;
						base_q   <= next_q;
						second_q <= 1'b1;
						state_q  <= S_LAW_GO;
					end
				end

				S_OUT: begin
					if (!out_valid_q || out_ready) begin
						out_valid_q <= 1'b1;
						action_q    <= res_action_q;
						mark_q      <= res_pos_q;
						state_q     <= S_IDLE;
					end
				end

				default: begin
					state_q <= S_IDLE;
				end
			endcase
		end
	end

	assign in_ready      = (state_q == S_IDLE);
	assign out_valid     = out_valid_q;
	assign action        = action_q;
	assign mark_position = mark_q;

endmodule

`default_nettype wire

>>> rtl/cmdc_isqrt.sv
`default_nettype none

// Bit-serial integer square root: consumes two operand bits per cycle from the
// top of a shift register and produces one root bit per cycle.
module cmdc_isqrt (
	input  wire logic                         clk,
	input  wire logic                         arst_n,
	input  wire logic                         start,
	input  wire logic [cmdc_pkg::COUNT_W-1:0] operand,
	output logic      [cmdc_pkg::ROOT_W-1:0]  root,
	output logic                              done
);
	import cmdc_pkg::*;

	localparam int STEPS  = COUNT_W / 2;
	localparam int STEP_W = $clog2(STEPS);
	localparam logic [STEP_W-1:0] LAST_STEP = STEP_W'(STEPS - 1);

	logic [COUNT_W-1:0] op_q;
	logic [ROOT_W-1:0]  root_q;
	logic [ROOT_W:0]    rem_q;
	logic [STEP_W-1:0]  step_q;
	logic               busy_q;
	logic               done_q;

	logic [ROOT_W+2:0]  rem_w;
	logic [ROOT_W+2:0]  trial_w;
	logic [ROOT_W+2:0]  diff_w;
	logic               take_w;

	assign rem_w   = {rem_q, op_q[COUNT_W-1 -: 2]};
	assign trial_w = {1'b0, root_q, 2'b01};
	assign diff_w  = rem_w - trial_w;
	assign take_w  = (rem_w >= trial_w);

	always_ff @(posedge clk or negedge arst_n) begin
		if (!arst_n) begin
			op_q   <= '0;
			root_q <= '0;
			rem_q  <= '0;
			step_q <= '0;
			busy_q <= 1'b0;
			done_q <= 1'b0;
		end else begin
			done_q <= 1'b0;
			if (start) begin
				op_q   <= operand;
				root_q <= '0;
				rem_q  <= '0;
				step_q <= '0;
				busy_q <= 1'b1;
			end else if (busy_q) begin
				op_q <= {op_q[COUNT_W-3:0], 2'b00};
				if (take_w) begin
					rem_q  <= diff_w[ROOT_W:0];
					root_q <= {root_q[ROOT_W-2:0], 1'b1};
				end else begin
					rem_q  <= rem_w[ROOT_W:0];
					root_q <= {root_q[ROOT_W-2:0], 1'b0};
				end
				step_q <= step_q + STEP_W'(1);
				if (step_q == LAST_STEP) begin
					busy_q <= 1'b0;
					done_q <= 1'b1;
				end
			end
		end
	end

	assign root = root_q;
	assign done = done_q;

endmodule

`default_nettype wire

>>> rtl/cmdc_div.sv
`default_nettype none

// Bit-serial restoring divider: one quotient bit per cycle, shifted in at the
// bottom of the dividend register while the dividend leaves at the top.
module cmdc_div (
	input  wire logic                        clk,
	input  wire logic                        arst_n,
	input  wire logic                        start,
	input  wire logic [cmdc_pkg::REG_W-1:0]  dividend,
	input  wire logic [cmdc_pkg::ROOT_W-1:0] divisor,
	output logic      [cmdc_pkg::REG_W-1:0]  quotient,
	output logic                             done
);
	import cmdc_pkg::*;

	localparam int STEP_W = $clog2(REG_W);
	localparam logic [STEP_W-1:0] LAST_STEP = STEP_W'(REG_W - 1);

	logic [REG_W-1:0]  quo_q;
	logic [ROOT_W-1:0] rem_q;
	logic [ROOT_W-1:0] dvs_q;
	logic [STEP_W-1:0] step_q;
	logic              busy_q;
	logic              done_q;

	logic [ROOT_W:0]   rem_w;
	logic [ROOT_W:0]   diff_w;
	logic              take_w;

	assign rem_w  = {rem_q, quo_q[REG_W-1]};
	assign diff_w = rem_w - {1'b0, dvs_q};
	assign take_w = (rem_w >= {1'b0, dvs_q});

	always_ff @(posedge clk or negedge arst_n) begin
		if (!arst_n) begin
			quo_q  <= '0;
			rem_q  <= '0;
			dvs_q  <= '0;
			step_q <= '0;
			busy_q <= 1'b0;
			done_q <= 1'b0;
		end else begin
			done_q <= 1'b0;
			if (start) begin
				quo_q  <= dividend;
				rem_q  <= '0;
				dvs_q  <= divisor;
				step_q <= '0;
				busy_q <= 1'b1;
			end else if (busy_q) begin
				if (take_w) begin
					rem_q <= diff_w[ROOT_W-1:0];
					quo_q <= {quo_q[REG_W-2:0], 1'b1};
				end else begin
					rem_q <= rem_w[ROOT_W-1:0];
					quo_q <= {quo_q[REG_W-2:0], 1'b0};
				end
				step_q <= step_q + STEP_W'(1);
				if (step_q == LAST_STEP) begin
					busy_q <= 1'b0;
					done_q <= 1'b1;
				end
			end
		end
	end

	assign quotient = quo_q;
	assign done     = done_q;

endmodule

`default_nettype wire
